@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define DQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define DQ_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define DQ_ASSERT(lbl, prop, msg)
`define DQ_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/deq_idx_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_idx_pkg
// Types, widths and codes shared by the indexed double-ended queue.
// ----------------------------------------------------------------------------
package deq_idx_pkg;

	// Ring store geometry. DEPTH is a power of two so ring wrap is truncation.
	localparam int DEPTH   = 256;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int OP_W    = 3;
	localparam int INDEX_W = 8;
	localparam int STAT_W  = 2;

	// Packed stream payloads, padded to whole bytes.
	localparam int IN_FIELDS_W  = OP_W + DATA_W + INDEX_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = DATA_W + STAT_W + CNT_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ_FRONT = 3'd4,
		OP_READ_BACK  = 3'd5,
		OP_READ_INDEX = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic exec;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/deq_idx_ram.sv @@
// ----------------------------------------------------------------------------
// deq_idx_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_idx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

@@ rtl/deq_idx_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_idx_ctrl
// Sequencer: takes an item, runs the operation, then hands off the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_idx_ctrl
	import deq_idx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Item is taken only while idle; the output register decouples the sink.
	assign s_tready    = (state_q == S_IDLE);
	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.emit    = (state_q == S_DONE) && sts.out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`DQ_ASSERT(a_exec_one_cycle, (state_q == S_EXEC) |=> (state_q == S_DONE), "exec not single cycle")
	`DQ_ASSERT(a_emit_then_idle, cmd.emit |=> (state_q == S_IDLE), "no return to idle after emit")
	`DQ_ASSERT(a_capture_to_exec, cmd.capture |=> cmd.exec, "captured item not executed")

endmodule

@@ rtl/deq_idx_dp.sv @@
// ----------------------------------------------------------------------------
// deq_idx_dp
// Datapath: item registers, head pointer, count, ring store and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_idx_dp
	import deq_idx_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts,
	input  op_t                    in_operation,
	input  logic [DATA_W-1:0]      in_value,
	input  logic [INDEX_W-1:0]     in_index,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	op_t                op_q;
	logic [DATA_W-1:0]  value_q;
	logic [INDEX_W-1:0] index_q;
	logic [ADDR_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]   count_q, count_d;
	status_t            res_status_q, status_d;
	logic               res_read_q;
	logic               ram_en, ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [DATA_W-1:0]  ram_rdata;
	logic               full, empty;
	logic [ADDR_W-1:0]  back_slot;
	logic               m_tvalid_q;
	logic [DATA_W-1:0]  out_data_q;
	status_t            out_status_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_empty_q;

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_operation;
			value_q <= in_value;
			index_q <= in_index;
		end
	end

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign back_slot = head_q + ADDR_W'(count_q - CNT_W'(1));

	// Operation decode: status, store access and pointer updates.
	always_comb begin
		status_d = ST_OK;
		head_d   = head_q;
		count_d  = count_q;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = head_q;
		unique case (op_q)
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = head_q + ADDR_W'(count_q);
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = head_q - ADDR_W'(1);
					head_d   = head_q - ADDR_W'(1);
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_en   = 1'b1;
					ram_addr = back_slot;
					count_d  = count_q - CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_en  = 1'b1;
					head_d  = head_q + ADDR_W'(1);
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_READ_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_en = 1'b1;
				end
			end
			OP_READ_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_en   = 1'b1;
					ram_addr = back_slot;
				end
			end
			OP_READ_INDEX: begin
				if (CNT_W'(index_q) >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					ram_en   = 1'b1;
					ram_addr = head_q + ADDR_W'(index_q);
				end
			end
			default: begin
				// Unused operation code does nothing.
			end
		endcase
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Result staging while the store read completes.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= status_d;
			res_read_q   <= ram_en && !ram_we;
		end
	end

	deq_idx_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en && cmd.exec),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (value_q),
		.rdata (ram_rdata)
	);

	// Output register.
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q   <= res_read_q ? ram_rdata : '0;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
			out_empty_q  <= (count_q == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_empty_q, out_count_q, out_status_q, out_data_q};

	`DQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`DQ_ASSERT(a_full_holds, (cmd.exec && status_d == ST_FULL) |=> $stable(count_q) && $stable(head_q), "full push changed state")
	`DQ_ASSERT(a_err_no_data, (m_tvalid_q && out_status_q != ST_OK) |-> (out_data_q == '0), "error result carries data")
	`DQ_ASSERT(a_empty_flag, m_tvalid_q |-> (out_empty_q == (out_count_q == '0)), "empty flag disagrees with count")

endmodule

@@ rtl/double_ended_queue_indexed.sv @@
// A result passes from the item registers through the store read into the output register once it is free.
// A new item is taken only while the sequencer is idle, after its capture, execute and result steps have
// handed the last result to the output register; the ring store is single-port with registered read.
// Reset: arst_n clears the head pointer, the count and all handshake state;
// the store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue_indexed
// Double-ended queue in a ring store with push/pop at both ends and indexed read.
// ----------------------------------------------------------------------------
module double_ended_queue_indexed
	import deq_idx_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// Fields from bit 0: operation[3], value[32], index[8], zero pad.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// Fields from bit 0: data[32], status[2], count[9], is_empty[1], zero pad.
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	deq_idx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	deq_idx_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_operation (op_t'(s_tdata[OP_W-1:0])),
		.in_value     (s_tdata[OP_W +: DATA_W]),
		.in_index     (s_tdata[OP_W + DATA_W +: INDEX_W]),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

endmodule
